>>> rtl/angle_of_arrival_smoother_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle-of-arrival smoother
// Shared concurrent assertion forms, reset-qualified, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ANGLE_OF_ARRIVAL_SMOOTHER_CORE_MACROS_SVH
`define ANGLE_OF_ARRIVAL_SMOOTHER_CORE_MACROS_SVH

// Expression must hold at every clock edge out of reset
`define AOAS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define AOAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define AOAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/aoas_pkg.sv
// ----------------------------------------------------------------------------
// Angle-of-arrival smoother package
// Shared widths, constants, register codes, unit handshake structs and the
// angle wrap helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aoas_pkg;

    // Angles are in 1/64 degree, wrapped to (-HALF_TURN, HALF_TURN]
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;
    localparam logic signed [16:0] FULL_TURN = 17'sd23040;

    localparam int CONFIRM_FRAMES_DEF = 12;

    // Field and datapath widths
    localparam int ANGLE_W    = 16;
    localparam int JUMP_W     = 14;
    localparam int TC_W       = 24;
    localparam int MOUNT_W    = 15;
    localparam int DIST_W     = 16;
    localparam int DT_W       = 20;
    localparam int OUT_ANG_W  = 15;
    localparam int DEST_W     = 32;
    localparam int ALPHA_W    = 16;
    localparam int ANG_MAG_W  = 14;
    localparam int DIST_MAG_W = 32;
    localparam int ACC_A_W    = ALPHA_W + ANG_MAG_W;
    localparam int ACC_D_W    = ALPHA_W + DIST_MAG_W;
    localparam int DEN_W      = TC_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_OFFSET  = 2'd2;
    localparam int CFG_DATA_W = TC_W;

    typedef logic signed [ANGLE_W-1:0] t_angle;

    // Request into the alpha/scale unit
    typedef struct packed {
        logic                  start;
        logic [DT_W-1:0]       time_step;
        logic [TC_W-1:0]       time_const;
        logic [ANG_MAG_W-1:0]  mag_a;
        logic [DIST_MAG_W-1:0] mag_d;
    } t_calc_req;

    // Rounded products back from the unit
    typedef struct packed {
        logic                  done;
        logic [ANG_MAG_W-1:0]  s_a;
        logic [DIST_MAG_W-1:0] s_d;
    } t_calc_rsp;

    // Wrap a value within one turn of the range back into (-HALF, HALF]
    function automatic t_angle wrap_turn(input logic signed [16:0] a);
        logic signed [16:0] v;
        v = a;
        if (a > HALF_TURN) begin
            v = a - FULL_TURN;
        end else if (a <= -HALF_TURN) begin
            v = a + FULL_TURN;
        end
        return v[ANGLE_W-1:0];
    endfunction

endpackage

>>> rtl/aoas_alpha_unit.sv
// ----------------------------------------------------------------------------
// Alpha and scale unit
// Restoring divider for alpha = dt*2^16/(tc+dt), then shift-add multiply of
// alpha by the angle and distance magnitudes, rounded to nearest at 2^-16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "angle_of_arrival_smoother_core_macros.svh"

module aoas_alpha_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aoas_pkg::t_calc_req i_req,
    output aoas_pkg::t_calc_rsp o_rsp
);

    localparam int StepW = $clog2(aoas_pkg::ALPHA_W);
    localparam int AlphaW = aoas_pkg::ALPHA_W;
    localparam int DenW = aoas_pkg::DEN_W;
    localparam int AccAW = aoas_pkg::ACC_A_W;
    localparam int AccDW = aoas_pkg::ACC_D_W;
    localparam int MagAW = aoas_pkg::ANG_MAG_W;
    localparam int MagDW = aoas_pkg::DIST_MAG_W;
    localparam logic [StepW-1:0] LastStep = StepW'(AlphaW - 1);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_DIV  = 4'b0010,
        P_MUL  = 4'b0100,
        P_RND  = 4'b1000
    } t_phase;

    t_phase r_phase, n_phase;
    logic [StepW-1:0] r_step, n_step;
    logic [DenW-1:0]  r_rem, n_rem;
    logic [DenW-1:0]  r_den, n_den;
    logic [AlphaW-1:0] r_quo, n_quo;
    logic [MagAW-1:0] r_mag_a, n_mag_a;
    logic [MagDW-1:0] r_mag_d, n_mag_d;
    logic [AccAW-1:0] r_acc_a, n_acc_a;
    logic [AccDW-1:0] r_acc_d, n_acc_d;
    logic             r_done, n_done;
    logic [MagAW-1:0] r_s_a, n_s_a;
    logic [MagDW-1:0] r_s_d, n_s_d;

    logic [DenW:0]    rem2;
    logic [DenW:0]    rem_sub;
    logic [AccAW:0]   sum_a;
    logic [AccDW:0]   sum_d;

    // Datapath: one divide step, one multiply step or the rounding adds
    always_comb begin
        rem2    = {r_rem, 1'b0};
        rem_sub = rem2 - {1'b0, r_den};
        sum_a   = {1'b0, r_acc_a} + (AccAW + 1)'(32768);
        sum_d   = {1'b0, r_acc_d} + (AccDW + 1)'(32768);

        n_phase = r_phase;
        n_step  = r_step;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        n_mag_a = r_mag_a;
        n_mag_d = r_mag_d;
        n_acc_a = r_acc_a;
        n_acc_d = r_acc_d;
        n_done  = 1'b0;
        n_s_a   = r_s_a;
        n_s_d   = r_s_d;

        case (r_phase)
            P_IDLE: begin
                // Load operands; top bits of the dividend give a zero quotient
                if (i_req.start) begin
                    n_rem   = DenW'(i_req.time_step);
                    n_den   = DenW'(i_req.time_const) + DenW'(i_req.time_step);
                    n_mag_a = i_req.mag_a;
                    n_mag_d = i_req.mag_d;
                    n_quo   = '0;
                    n_step  = '0;
                    n_phase = P_DIV;
                end
            end
            P_DIV: begin
                // Shift in a zero, subtract when it fits
                if (!rem_sub[DenW]) begin
                    n_rem = rem_sub[DenW-1:0];
                    n_quo = {r_quo[AlphaW-2:0], 1'b1};
                end else begin
                    n_rem = rem2[DenW-1:0];
                    n_quo = {r_quo[AlphaW-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == LastStep) begin
                    n_acc_a = '0;
                    n_acc_d = '0;
                    n_step  = '0;
                    n_phase = P_MUL;
                end
            end
            P_MUL: begin
                // Multiply MSB first over the alpha bits
                n_acc_a = {r_acc_a[AccAW-2:0], 1'b0}
                        + (r_quo[AlphaW-1] ? AccAW'(r_mag_a) : '0);
                n_acc_d = {r_acc_d[AccDW-2:0], 1'b0}
                        + (r_quo[AlphaW-1] ? AccDW'(r_mag_d) : '0);
                n_quo   = {r_quo[AlphaW-2:0], 1'b0};
                n_step  = r_step + 1'b1;
                if (r_step == LastStep) begin
                    n_phase = P_RND;
                end
            end
            P_RND: begin
                // Round half up on the magnitude, drop the fraction
                n_s_a   = sum_a[16 +: MagAW];
                n_s_d   = sum_d[16 +: MagDW];
                n_done  = 1'b1;
                n_phase = P_IDLE;
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quo   <= n_quo;
        r_mag_a <= n_mag_a;
        r_mag_d <= n_mag_d;
        r_acc_a <= n_acc_a;
        r_acc_d <= n_acc_d;
        r_s_a   <= n_s_a;
        r_s_d   <= n_s_d;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.s_a  = r_s_a;
    assign o_rsp.s_d  = r_s_d;

    `AOAS_ASSERT_IMPLY(a_rem_below_den, i_clk, i_rst_n, r_phase == P_DIV, r_rem < r_den, "remainder reached divisor")
    `AOAS_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held more than one cycle")
    `AOAS_ASSERT_IMPLY(a_start_idle, i_clk, i_rst_n, i_req.start, r_phase == P_IDLE, "start while busy")

endmodule

>>> rtl/angle_of_arrival_smoother_core.sv
// ----------------------------------------------------------------------------
// Angle-of-arrival smoother core
// First-order low-pass on azimuth and distance with jump confirmation.
// ----------------------------------------------------------------------------
// One sample at a time. A sample that is smoothed passes, from its transfer in
// until the next sample can be taken, through the wrap and decide states, 16
// steps of the shared divider for alpha, 16 shift-add steps of the same unit
// for both products, the rounding step, the registered hand-back of the
// products, the update state, the result load and the idle state in which the
// next transfer lands. A snap or a held-back jump passes through wrap, decide,
// the result load and idle, and a rejected sample skips decide. A result that
// finds the last one still waiting on the output stall holds the sequencer at
// the result load. The result sits in an output register, so a new sample is taken while it waits.
// Configuration is accepted only while no sample is in progress.
`timescale 1ns / 1ps

`include "angle_of_arrival_smoother_core_macros.svh"

module angle_of_arrival_smoother_core #(
    parameter int CONFIRM_FRAMES = aoas_pkg::CONFIRM_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aoas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [aoas_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_sample_valid,
    input  logic signed [aoas_pkg::ANGLE_W-1:0] i_raw_angle,
    input  logic [aoas_pkg::DIST_W-1:0]         i_raw_distance,
    input  logic [aoas_pkg::DT_W-1:0]           i_time_step,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_accepted,
    output logic signed [aoas_pkg::OUT_ANG_W-1:0] o_filtered_angle,
    output logic [aoas_pkg::DIST_W-1:0]         o_filtered_distance,
    output logic signed [aoas_pkg::OUT_ANG_W-1:0] o_body_angle
);

    localparam int CntW = $clog2(CONFIRM_FRAMES + 1);
    localparam logic [CntW-1:0] ConfirmCnt = CntW'(CONFIRM_FRAMES);
    localparam int AngW = aoas_pkg::ANGLE_W;
    localparam int JumpW = aoas_pkg::JUMP_W;
    localparam int DestW = aoas_pkg::DEST_W;
    localparam int MagAW = aoas_pkg::ANG_MAG_W;
    localparam int OutAngW = aoas_pkg::OUT_ANG_W;
    localparam int DistW = aoas_pkg::DIST_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WRAP   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_CALC   = 6'b001000,
        S_UPDATE = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [JumpW-1:0]              r_jump_limit, n_jump_limit;
    logic [aoas_pkg::TC_W-1:0]     r_time_const, n_time_const;
    logic signed [aoas_pkg::MOUNT_W-1:0] r_mount, n_mount;

    // Filter state
    aoas_pkg::t_angle r_angle_est, n_angle_est;
    logic [DestW-1:0] r_dist_est, n_dist_est;
    aoas_pkg::t_angle r_cand_angle, n_cand_angle;
    logic [CntW-1:0]  r_cand_cnt, n_cand_cnt;
    aoas_pkg::t_angle r_last_angle, n_last_angle;
    logic             r_have_last, n_have_last;
    logic             r_started, n_started;

    // Held sample and per-sample working values
    logic             r_smp_valid;
    aoas_pkg::t_angle r_raw_angle;
    logic [DistW-1:0] r_raw_dist;
    logic [aoas_pkg::DT_W-1:0] r_dt;
    aoas_pkg::t_angle r_w, n_w;
    logic             r_accept, n_accept;
    logic             r_neg_a, n_neg_a;
    logic             r_neg_d, n_neg_d;

    // Result register
    logic             r_out_valid, n_out_valid;
    logic             r_out_acc;
    logic signed [OutAngW-1:0] r_out_angle;
    logic [DistW-1:0] r_out_dist;
    logic signed [OutAngW-1:0] r_out_body;

    aoas_pkg::t_calc_req calc_req;
    aoas_pkg::t_calc_rsp calc_rsp;

    logic             in_xfer, out_xfer, cfg_xfer, out_load;
    aoas_pkg::t_angle d_last, d_cand, d_est, ang_upd, body;
    logic [AngW-1:0]  abs_last, abs_cand, abs_est;
    logic             is_jump, cand_far, confirm, snap;
    logic [CntW-1:0]  cnt_next;
    logic [DestW-1:0] dist_target;
    logic [DestW:0]   dist_diff;
    logic [DestW-1:0] mag_d;
    logic signed [16:0] ang_sum;
    logic signed [16:0] s_a_signed;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Decode: jump test, candidate agreement, smoothing differences
    always_comb begin
        d_last   = aoas_pkg::wrap_turn(17'(r_w) - 17'(r_last_angle));
        d_cand   = aoas_pkg::wrap_turn(17'(r_w) - 17'(r_cand_angle));
        d_est    = aoas_pkg::wrap_turn(17'(r_w) - 17'(r_angle_est));
        abs_last = d_last[AngW-1] ? $unsigned(-d_last) : $unsigned(d_last);
        abs_cand = d_cand[AngW-1] ? $unsigned(-d_cand) : $unsigned(d_cand);
        abs_est  = d_est[AngW-1] ? $unsigned(-d_est) : $unsigned(d_est);
        is_jump  = r_have_last && (r_jump_limit != '0)
                && (abs_last > AngW'(r_jump_limit));
        cand_far = abs_cand > AngW'(r_jump_limit);
        cnt_next = ((r_cand_cnt == '0) || cand_far) ? CntW'(1) : r_cand_cnt + 1'b1;
        confirm  = cnt_next >= ConfirmCnt;
        snap     = !r_started || (r_time_const == '0) || (r_dt == '0);

        dist_target = {r_raw_dist, 16'b0};
        dist_diff   = {1'b0, dist_target} - {1'b0, r_dist_est};
        mag_d       = dist_diff[DestW] ? (r_dist_est - dist_target) : dist_diff[DestW-1:0];

        // Apply the rounded step on the circle
        s_a_signed = r_neg_a ? -$signed(17'(calc_rsp.s_a)) : $signed(17'(calc_rsp.s_a));
        ang_sum    = 17'(r_angle_est) + s_a_signed;
        ang_upd    = aoas_pkg::wrap_turn(ang_sum);

        body = aoas_pkg::wrap_turn(17'(r_mount) - 17'(r_angle_est));
    end

    assign calc_req.start      = (r_state == S_DECIDE) && !is_jump && !snap;
    assign calc_req.time_step  = r_dt;
    assign calc_req.time_const = r_time_const;
    assign calc_req.mag_a      = abs_est[MagAW-1:0];
    assign calc_req.mag_d      = mag_d;

    aoas_alpha_unit u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (calc_req),
        .o_rsp   (calc_rsp)
    );

    // Sequencer and state update
    always_comb begin
        n_state      = r_state;
        n_jump_limit = r_jump_limit;
        n_time_const = r_time_const;
        n_mount      = r_mount;
        n_angle_est  = r_angle_est;
        n_dist_est   = r_dist_est;
        n_cand_angle = r_cand_angle;
        n_cand_cnt   = r_cand_cnt;
        n_last_angle = r_last_angle;
        n_have_last  = r_have_last;
        n_started    = r_started;
        n_w          = r_w;
        n_accept     = r_accept;
        n_neg_a      = r_neg_a;
        n_neg_d      = r_neg_d;
        n_out_valid  = r_out_valid;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Register writes; a changed jump limit drops the candidate
                if (cfg_xfer) begin
                    case (i_cfg_index)
                        aoas_pkg::CFG_JUMP_LIMIT: begin
                            if (i_cfg_data[JumpW-1:0] != r_jump_limit) begin
                                n_jump_limit = i_cfg_data[JumpW-1:0];
                                n_cand_cnt   = '0;
                            end
                        end
                        aoas_pkg::CFG_TIME_CONSTANT: begin
                            n_time_const = i_cfg_data;
                        end
                        aoas_pkg::CFG_MOUNT_OFFSET: begin
                            n_mount = $signed(i_cfg_data[aoas_pkg::MOUNT_W-1:0]);
                        end
                        default: begin
                        end
                    endcase
                end
                if (in_xfer) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                // Wrap the raw angle; drop invalid samples straight to the result
                n_w = aoas_pkg::wrap_turn(17'(r_raw_angle));
                if (!r_smp_valid || (r_raw_dist == '0)) begin
                    n_accept = 1'b0;
                    n_state  = S_OUT;
                end else begin
                    n_accept = 1'b1;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (is_jump) begin
                    // Hold back the jump, confirm after enough agreeing samples
                    n_cand_angle = r_w;
                    n_dist_est   = dist_target;
                    if (confirm) begin
                        n_angle_est  = r_w;
                        n_last_angle = r_w;
                        n_have_last  = 1'b1;
                        n_cand_cnt   = '0;
                    end else begin
                        n_cand_cnt = cnt_next;
                    end
                    n_state = S_OUT;
                end else begin
                    n_cand_cnt   = '0;
                    n_last_angle = r_w;
                    n_have_last  = 1'b1;
                    if (snap) begin
                        n_angle_est = r_w;
                        n_dist_est  = dist_target;
                        n_started   = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_neg_a = d_est[AngW-1];
                        n_neg_d = dist_diff[DestW];
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: begin
                if (calc_rsp.done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // Step both estimates toward the sample
                n_angle_est = ang_upd;
                n_dist_est  = r_neg_d ? (r_dist_est - calc_rsp.s_d)
                                      : (r_dist_est + calc_rsp.s_d);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_jump_limit <= '0;
            r_time_const <= '0;
            r_mount      <= '0;
            r_angle_est  <= '0;
            r_dist_est   <= '0;
            r_cand_angle <= '0;
            r_cand_cnt   <= '0;
            r_last_angle <= '0;
            r_have_last  <= 1'b0;
            r_started    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_jump_limit <= n_jump_limit;
            r_time_const <= n_time_const;
            r_mount      <= n_mount;
            r_angle_est  <= n_angle_est;
            r_dist_est   <= n_dist_est;
            r_cand_angle <= n_cand_angle;
            r_cand_cnt   <= n_cand_cnt;
            r_last_angle <= n_last_angle;
            r_have_last  <= n_have_last;
            r_started    <= n_started;
            r_out_valid  <= n_out_valid;
        end
    end

    // Capture the sample on transfer; hold working values
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_smp_valid <= i_sample_valid;
            r_raw_angle <= i_raw_angle;
            r_raw_dist  <= i_raw_distance;
            r_dt        <= i_time_step;
        end
        r_w      <= n_w;
        r_accept <= n_accept;
        r_neg_a  <= n_neg_a;
        r_neg_d  <= n_neg_d;
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_acc   <= r_accept;
            r_out_angle <= r_angle_est[OutAngW-1:0];
            r_out_dist  <= r_dist_est[DestW-1 -: DistW];
            r_out_body  <= body[OutAngW-1:0];
        end
    end

    assign o_cfg_ready         = (r_state == S_IDLE);
    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_accepted          = r_out_acc;
    assign o_filtered_angle    = r_out_angle;
    assign o_filtered_distance = r_out_dist;
    assign o_body_angle        = r_out_body;

    `AOAS_ASSERT_ALWAYS(a_angle_range, i_clk, i_rst_n, (r_angle_est > -17'sd11520) && (r_angle_est <= 17'sd11520), "angle estimate out of range")
    `AOAS_ASSERT_ALWAYS(a_cnt_below_confirm, i_clk, i_rst_n, r_cand_cnt < ConfirmCnt, "candidate count reached confirm")
    `AOAS_ASSERT_IMPLY(a_done_in_calc, i_clk, i_rst_n, calc_rsp.done, r_state == S_CALC, "unit done outside calc")
    `AOAS_ASSERT_IMPLY(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT), "result valid without load")

endmodule
